// ===== rtl/ima_adpcm_block_decoder_macros.svh =====
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_BLOCK_DECODER_MACROS_SVH

`define IMADEC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define IMADEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/imadec_pkg.sv =====
package imadec_pkg;

  localparam int COUNTER_WIDTH_DEF = 25;
  localparam int QUEUE_DEPTH       = 2;
  localparam int LOOP_W            = 24;
  localparam int RING_W            = 17;
  localparam int CFG_W             = 24;
  localparam int NUM_STEPS         = 89;

  localparam logic [6:0]         MAX_INDEX    = 7'd88;
  localparam logic signed [17:0] PRED_MAX     = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN     = -18'sd32767;
  localparam logic [RING_W-1:0]  RING_LEN_RST = RING_W'(16384);

  localparam logic [0:0] REG_LOOP_SAMPLE = 1'b0;
  localparam logic [0:0] REG_RING_LENGTH = 1'b1;

  typedef enum logic {
    OP_HEADER,
    OP_DATA
  } op_kind_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] header_predictor;
    logic [7:0]         header_index;
    logic [7:0]         data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [15:0]        ring_index;
    logic               last_of_item;
    logic signed [15:0] loop_predictor_out;
    logic [6:0]         loop_index_out;
  } out_item_t;

  typedef struct packed {
    op_kind_e           kind;
    logic signed [15:0] predictor;
    logic [6:0]         index;
    logic [7:0]         codes;
  } op_t;

  typedef struct packed {
    logic [LOOP_W-1:0] loop_sample;
    logic [RING_W-1:0] ring_length;
  } cfg_t;

  localparam logic [15:0] STEP_TABLE [NUM_STEPS] = '{
    16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
    16'h0010, 16'h0011, 16'h0013, 16'h0015, 16'h0017, 16'h0019, 16'h001C, 16'h001F,
    16'h0022, 16'h0025, 16'h0029, 16'h002D, 16'h0032, 16'h0037, 16'h003C, 16'h0042,
    16'h0049, 16'h0050, 16'h0058, 16'h0061, 16'h006B, 16'h0076, 16'h0082, 16'h008F,
    16'h009D, 16'h00AD, 16'h00BE, 16'h00D1, 16'h00E6, 16'h00FD, 16'h0117, 16'h0133,
    16'h0151, 16'h0173, 16'h0198, 16'h01C1, 16'h01EE, 16'h0220, 16'h0256, 16'h0292,
    16'h02D4, 16'h031C, 16'h036C, 16'h03C3, 16'h0424, 16'h048E, 16'h0502, 16'h0583,
    16'h0610, 16'h06AB, 16'h0756, 16'h0812, 16'h08E0, 16'h09C3, 16'h0ABD, 16'h0BD0,
    16'h0CFF, 16'h0E4C, 16'h0FBA, 16'h114C, 16'h1307, 16'h14EE, 16'h1706, 16'h1954,
    16'h1BDC, 16'h1EA5, 16'h21B6, 16'h2515, 16'h28CA, 16'h2CDF, 16'h315B, 16'h364B,
    16'h3BB9, 16'h41B2, 16'h4844, 16'h4F7E, 16'h5771, 16'h602F, 16'h69CE, 16'h7462,
    16'h7FFF
  };

  function automatic logic [15:0] step_of(logic [6:0] idx);
    logic [6:0] sel;
    sel = (idx > MAX_INDEX) ? MAX_INDEX : idx;
    return STEP_TABLE[sel];
  endfunction

  function automatic logic [6:0] next_index(logic [6:0] idx, logic [2:0] code);
    logic [7:0] up;
    logic [6:0] res;
    up = {1'b0, idx} + {5'd0, code[1:0], 1'b0} + 8'd2;
    if (!code[2]) begin
      res = (idx == 7'd0) ? 7'd0 : idx - 7'd1;
    end else begin
      res = (up > {1'b0, MAX_INDEX}) ? MAX_INDEX : up[6:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/imadec_fifo.sv =====
module imadec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/imadec_front.sv =====
module imadec_front #(
  parameter int DEPTH = imadec_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  imadec_pkg::in_item_t item_i,
  output logic                 full_o,
  output imadec_pkg::op_t      op_o,
  output logic                 op_valid_o,
  input  logic                 op_pop_i
);

  import imadec_pkg::*;

  op_t  op_in;
  logic empty;

  // classify and clamp the header index before queueing
  always_comb begin
    op_in.kind      = item_i.cmd ? OP_DATA : OP_HEADER;
    op_in.predictor = item_i.header_predictor;
    op_in.index     = (item_i.header_index > {1'b0, MAX_INDEX}) ? MAX_INDEX
                                                                : item_i.header_index[6:0];
    op_in.codes     = item_i.data_byte;
  end

  imadec_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (op_in),
    .full_o  (full_o),
    .pop_i   (op_pop_i),
    .data_o  (op_o),
    .empty_o (empty)
  );

  assign op_valid_o = !empty;

endmodule

// ===== rtl/imadec_core.sv =====
module imadec_core #(
  parameter int COUNTER_WIDTH = imadec_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imadec_pkg::cfg_t      cfg_i,
  input  imadec_pkg::op_t       op_i,
  input  logic                  op_valid_i,
  output logic                  op_pop_o,
  output logic                  out_push_o,
  output imadec_pkg::out_item_t out_o,
  input  logic                  out_full_i
);

  import imadec_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > LOOP_W) ? COUNTER_WIDTH : LOOP_W;

  logic signed [15:0]     pred_q, pred_d, loop_pred_q, loop_pred_d;
  logic [6:0]             idx_q, idx_d, loop_idx_q, loop_idx_d;
  logic [15:0]            wpos_q, wpos_d;
  logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
  logic                   phase_q, phase_d;

  logic                   fire, is_hdr, last, capture, count_up, wrap;
  logic [3:0]             code;
  logic [15:0]            step;
  logic [16:0]            diff, wpos_inc;
  logic signed [17:0]     sum;
  logic signed [15:0]     sat;
  logic [CMP_W-1:0]       cnt_ext, loop_ext;

  assign fire   = op_valid_i && !out_full_i;
  assign is_hdr = (op_i.kind == OP_HEADER);
  assign last   = is_hdr || phase_q;
  assign code   = phase_q ? op_i.codes[7:4] : op_i.codes[3:0];
  assign step   = step_of(idx_q);

  always_comb begin
    diff = {4'd0, step[15:3]};
    if (code[0]) diff = diff + {3'd0, step[15:2]};
    if (code[1]) diff = diff + {2'd0, step[15:1]};
    if (code[2]) diff = diff + {1'b0, step};
  end

  always_comb begin
    if (code[3]) begin
      sum = 18'(pred_q) - $signed({1'b0, diff});
      sat = (sum < PRED_MIN) ? PRED_MIN[15:0] : sum[15:0];
    end else begin
      sum = 18'(pred_q) + $signed({1'b0, diff});
      sat = (sum > PRED_MAX) ? PRED_MAX[15:0] : sum[15:0];
    end
  end

  assign pred_d = is_hdr ? op_i.predictor : sat;
  assign idx_d  = is_hdr ? op_i.index : next_index(idx_q, code[2:0]);

  // ring position and loop bookkeeping
  assign wpos_inc = {1'b0, wpos_q} + 17'd1;
  assign wrap     = (wpos_inc >= cfg_i.ring_length) || wpos_inc[16];
  assign wpos_d   = wrap ? '0 : wpos_inc[15:0];

  assign cnt_ext  = CMP_W'(cnt_q);
  assign loop_ext = CMP_W'(cfg_i.loop_sample);
  assign capture  = (cnt_ext == loop_ext);
  assign count_up = (cnt_ext <= loop_ext) && !(&cnt_q);
  assign cnt_d    = count_up ? cnt_q + COUNTER_WIDTH'(1) : cnt_q;

  assign loop_pred_d = capture ? pred_d : loop_pred_q;
  assign loop_idx_d  = capture ? idx_d : loop_idx_q;
  assign phase_d     = is_hdr ? 1'b0 : !phase_q;

  assign out_push_o = fire;
  assign op_pop_o   = fire && last;

  always_comb begin
    out_o.sample             = pred_d;
    out_o.ring_index         = wpos_q;
    out_o.last_of_item       = last;
    out_o.loop_predictor_out = loop_pred_d;
    out_o.loop_index_out     = loop_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q      <= '0;
      idx_q       <= '0;
      wpos_q      <= '0;
      cnt_q       <= '0;
      loop_pred_q <= '0;
      loop_idx_q  <= '0;
      phase_q     <= 1'b0;
    end else if (fire) begin
      pred_q      <= pred_d;
      idx_q       <= idx_d;
      wpos_q      <= wpos_d;
      cnt_q       <= cnt_d;
      loop_pred_q <= loop_pred_d;
      loop_idx_q  <= loop_idx_d;
      phase_q     <= phase_d;
    end
  end

endmodule

// ===== rtl/ima_adpcm_block_decoder.sv =====
// Block IMA ADPCM decoder. Items enter through a small input queue (push/full)
// and results leave through a small output queue (empty/pop). A header item
// yields one sample, a data byte yields two, low nibble first; the back-end
// datapath makes one sample per clock while the result queue has room, and an
// item leaves the input queue with its last sample. An item is registered in
// the input queue and its result in the result queue before it shows on the
// result ports. Configuration writes are meant for an idle block only.
module ima_adpcm_block_decoder #(
  parameter int COUNTER_WIDTH = imadec_pkg::COUNTER_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = imadec_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [imadec_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                         push,
  input  imadec_pkg::in_item_t         item_i,
  output logic                         full,
  output logic                         empty,
  input  logic                         pop,
  output imadec_pkg::out_item_t        result_o
);

  import imadec_pkg::*;

  cfg_t      cfg_q;
  op_t       op;
  logic      op_valid, op_pop, out_push, out_full;
  out_item_t out_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_sample <= '0;
      cfg_q.ring_length <= RING_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOOP_SAMPLE: cfg_q.loop_sample <= cfg_wdata_i[LOOP_W-1:0];
        REG_RING_LENGTH: cfg_q.ring_length <= cfg_wdata_i[RING_W-1:0];
        default: ;
      endcase
    end
  end

  imadec_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop)
  );

  imadec_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .out_push_o (out_push),
    .out_o      (out_item),
    .out_full_i (out_full)
  );

  imadec_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

`include "ima_adpcm_block_decoder_macros.svh"

  // a sample beat is only made when its op is present and the result queue has room
  `IMADEC_ASSERT_IMPLY(a_push_has_room, out_push, op_valid && !out_full, "beat without room")
  `IMADEC_ASSERT_IMPLY(a_pop_on_last, op_pop, out_push && out_item.last_of_item, "early retire")
  `IMADEC_ASSERT_IMPLY(a_loop_idx, !empty, result_o.loop_index_out <= MAX_INDEX, "bad loop index")

endmodule
